// ===== sv/assert_macros.svh =====
// assertion macros used by the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off during reset
`define SNDRF_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sound register file check failed");

// next-cycle implication, off during reset
`define SNDRF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sound register file check failed");

`endif

// ===== sv/sndrf_pkg.sv =====
// types, address map and mask tables of the sound unit register file
// no dependencies
package sndrf_pkg;

  localparam logic REQ_READ  = 1'b0;
  localparam logic REQ_WRITE = 1'b1;

  localparam logic [15:0] REG_BASE  = 16'hFF10;
  localparam logic [15:0] WAVE_BASE = 16'hFF30;
  localparam int          REG_COUNT = 23;
  localparam int          REG_IDX_W = 5;
  localparam logic [7:0]  OPEN_BUS  = 8'hFF;

  typedef struct packed {
    logic        req_type;
    logic [15:0] bus_address;
    logic [7:0]  write_data;
  } snd_req_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       mapped;
  } snd_rsp_t;

  // per offset from REG_BASE
  localparam logic REG_MAPPED [REG_COUNT] = '{
    1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1,
    1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0,
    1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1
  };
  localparam logic [7:0] REG_RESET [REG_COUNT] = '{
    8'h80, 8'hBF, 8'hF3, 8'hFF, 8'hBF, 8'hFF, 8'h3F, 8'h00,
    8'hFF, 8'hBF, 8'h7F, 8'hFF, 8'h9F, 8'hFF, 8'hBF, 8'hFF,
    8'hFF, 8'h00, 8'h00, 8'hBF, 8'h77, 8'hF3, 8'hF1
  };
  localparam logic [7:0] WR_MASK [REG_COUNT] = '{
    8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'hFF, 8'hFF,
    8'hFF, 8'hFF, 8'h80, 8'hFF, 8'h60, 8'hFF, 8'hC7, 8'h00,
    8'hFF, 8'hFF, 8'hFF, 8'hC0, 8'hFF, 8'hFF, 8'h80
  };
  localparam logic [7:0] RD_MASK [REG_COUNT] = '{
    8'hFF, 8'hC0, 8'hFF, 8'h00, 8'h78, 8'h00, 8'hFF, 8'hFF,
    8'h00, 8'h78, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'h40, 8'h00,
    8'hFF, 8'hFF, 8'hFF, 8'h7F, 8'hFF, 8'hFF, 8'hFF
  };
  localparam logic [7:0] RD_FILL [REG_COUNT] = '{
    8'h00, 8'h00, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'h00,
    8'hFF, 8'h00, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
  };

endpackage

// ===== sv/sound_unit_register_file.sv =====
// latency: a request's response is valid in the cycle after the request is taken
// throughput: one request per cycle while the response register is empty or taken
// reset (rst_n, synchronous): registers return to their power-on values, the wave
// store clears to zero and no response is pending
// depends on sndrf_pkg
module sound_unit_register_file
  import sndrf_pkg::*;
#(
  parameter int WAVE_BYTES = 16
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  snd_req_t in_req,
  output logic     out_valid,
  input  logic     out_ready,
  output snd_rsp_t out_rsp
);

  localparam int WIDX_W = $clog2(WAVE_BYTES);

  logic [7:0]  reg_r  [REG_COUNT];
  logic [7:0]  wave_r [WAVE_BYTES];
  logic        out_valid_r;
  snd_rsp_t    rsp_r;
  snd_rsp_t    rsp_nxt;

  logic              take;
  logic [15:0]       reg_off;
  logic [15:0]       wave_off;
  logic [REG_IDX_W-1:0] ridx;
  logic [WIDX_W-1:0] widx;
  logic              in_reg_range;
  logic              hit_reg;
  logic              hit_wave;
  logic              is_write;

  assign in_ready  = !out_valid_r || out_ready;
  assign take      = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_rsp   = rsp_r;
  assign is_write  = (in_req.req_type == REQ_WRITE);

  // address decode
  assign reg_off      = in_req.bus_address - REG_BASE;
  assign wave_off     = in_req.bus_address - WAVE_BASE;
  assign ridx         = reg_off[REG_IDX_W-1:0];
  assign widx         = wave_off[WIDX_W-1:0];
  assign in_reg_range = (in_req.bus_address >= REG_BASE) &&
                        (reg_off < 16'(REG_COUNT));
  assign hit_reg      = in_reg_range && REG_MAPPED[ridx];
  assign hit_wave     = (in_req.bus_address >= WAVE_BASE) &&
                        (wave_off < 16'(WAVE_BYTES));

  always_comb begin
    rsp_nxt.read_data = OPEN_BUS;
    rsp_nxt.mapped    = hit_reg || hit_wave;
    if (!is_write) begin
      if (hit_reg) begin
        rsp_nxt.read_data = (reg_r[ridx] & RD_MASK[ridx]) | RD_FILL[ridx];
      end else if (hit_wave) begin
        rsp_nxt.read_data = wave_r[widx];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < REG_COUNT; i++) begin
        reg_r[i] <= REG_RESET[i];
      end
      for (int i = 0; i < WAVE_BYTES; i++) begin
        wave_r[i] <= 8'h00;
      end
    end else if (take && is_write) begin
      if (hit_reg) begin
        reg_r[ridx] <= (reg_r[ridx] & ~WR_MASK[ridx]) |
                       (in_req.write_data & WR_MASK[ridx]);
      end else if (hit_wave) begin
        wave_r[widx] <= in_req.write_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (take) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      rsp_r <= rsp_nxt;
    end
  end

endmodule

// ===== sv/sndrf_checker.sv =====
// port-level checks of the sound unit register file, bound to the top level
// depends on sndrf_pkg and assert_macros.svh
`include "assert_macros.svh"

module sndrf_checker
  import sndrf_pkg::*;
(
  input logic     clk,
  input logic     rst_n,
  input logic     in_valid,
  input logic     in_ready,
  input snd_req_t in_req,
  input logic     out_valid,
  input logic     out_ready,
  input snd_rsp_t out_rsp
);

  // stalled response holds
  `SNDRF_ASSERT_NEXT(a_rsp_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_rsp))
  // every taken request yields a response next cycle
  `SNDRF_ASSERT_NEXT(a_rsp_follows, clk, rst_n, in_valid && in_ready, out_valid)
  // unmapped reads the open bus value
  `SNDRF_ASSERT_IMPL(a_unmapped_ff, clk, rst_n, out_valid && !out_rsp.mapped, out_rsp.read_data == OPEN_BUS)
  // a write never returns data
  `SNDRF_ASSERT_NEXT(a_write_ff, clk, rst_n, in_valid && in_ready && (in_req.req_type == REQ_WRITE), out_rsp.read_data == OPEN_BUS)

endmodule

bind sound_unit_register_file sndrf_checker u_sndrf_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_req    (in_req),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_rsp   (out_rsp)
);

// ===== test/sound_unit_register_file_tb.sv =====
// testbench for sound_unit_register_file: register masks, wave store and unmapped decode
// keeps its own copy of the register bank and compares every response in order
// depends on sndrf_pkg and sound_unit_register_file
`timescale 1ns / 1ps

module sound_unit_register_file_tb;
  import sndrf_pkg::*;

  localparam logic [15:0] SND_FIRST  = 16'hFF10;
  localparam logic [15:0] SND_LAST   = 16'hFF26;
  localparam logic [15:0] WAVE_FIRST = 16'hFF30;
  localparam logic [15:0] WAVE_LAST  = 16'hFF3F;
  localparam int          NUM_SLOTS  = 23;
  localparam int          NUM_WAVE   = 16;
  localparam int          MAX_IDLE   = 13;

  localparam logic SLOT_USED [NUM_SLOTS] = '{
    1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1,
    1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0,
    1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1
  };
  localparam logic [7:0] SLOT_INIT [NUM_SLOTS] = '{
    8'h80, 8'hBF, 8'hF3, 8'hFF, 8'hBF, 8'h00, 8'h3F, 8'h00,
    8'hFF, 8'hBF, 8'h7F, 8'hFF, 8'h9F, 8'hFF, 8'hBF, 8'h00,
    8'hFF, 8'h00, 8'h00, 8'hBF, 8'h77, 8'hF3, 8'hF1
  };
  localparam logic [7:0] SLOT_WBITS [NUM_SLOTS] = '{
    8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'hFF, 8'hFF,
    8'hFF, 8'hFF, 8'h80, 8'hFF, 8'h60, 8'hFF, 8'hC7, 8'h00,
    8'hFF, 8'hFF, 8'hFF, 8'hC0, 8'hFF, 8'hFF, 8'h80
  };
  localparam logic [7:0] SLOT_RBITS [NUM_SLOTS] = '{
    8'hFF, 8'hC0, 8'hFF, 8'h00, 8'h78, 8'h00, 8'hFF, 8'hFF,
    8'h00, 8'h78, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'h40, 8'h00,
    8'hFF, 8'hFF, 8'hFF, 8'h7F, 8'hFF, 8'hFF, 8'hFF
  };
  localparam logic [7:0] SLOT_RSET [NUM_SLOTS] = '{
    8'h00, 8'h00, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'h00,
    8'hFF, 8'h00, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
  };

  logic     clk = 1'b0;
  logic     rst_n;
  logic     in_valid;
  logic     in_ready;
  snd_req_t in_req;
  logic     out_valid;
  logic     out_ready;
  snd_rsp_t out_rsp;

  logic [7:0] slot_shadow [NUM_SLOTS];
  logic [7:0] wave_shadow [NUM_WAVE];
  snd_rsp_t   access_rsp_q [$];
  int         mismatch_count = 0;
  bit         tx_idle_on = 1'b1;
  bit         rx_idle_on = 1'b1;

  sound_unit_register_file DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_rsp   (out_rsp)
  );

  always #2 clk = ~clk;

  function automatic snd_rsp_t decode_access(snd_req_t r);
    snd_rsp_t rsp;
    int       off;
    rsp.read_data = 8'hFF;
    rsp.mapped    = 1'b0;
    if (r.bus_address >= SND_FIRST && r.bus_address <= SND_LAST) begin
      off = int'(r.bus_address - SND_FIRST);
      if (SLOT_USED[off]) begin
        rsp.mapped = 1'b1;
        if (r.req_type == REQ_WRITE) begin
          slot_shadow[off] = (slot_shadow[off] & ~SLOT_WBITS[off]) |
                             (r.write_data & SLOT_WBITS[off]);
        end else begin
          rsp.read_data = (slot_shadow[off] & SLOT_RBITS[off]) | SLOT_RSET[off];
        end
      end
    end else if (r.bus_address >= WAVE_FIRST && r.bus_address <= WAVE_LAST) begin
      off = int'(r.bus_address - WAVE_FIRST);
      rsp.mapped = 1'b1;
      if (r.req_type == REQ_WRITE) begin
        wave_shadow[off] = r.write_data;
      end else begin
        rsp.read_data = wave_shadow[off];
      end
    end
    return rsp;
  endfunction

  task automatic report_mismatch(string what, logic [7:0] want, logic [7:0] got);
    $display("%0t mismatch %s: expected %02h got %02h", $realtime, what, want, got);
    mismatch_count++;
  endtask

  task automatic send_request(logic kind, logic [15:0] addr, logic [7:0] data);
    int gap;
    gap = tx_idle_on ? $urandom_range(0, MAX_IDLE) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req   <= '{req_type: kind, bus_address: addr, write_data: data};
    do @(posedge clk); while (in_ready !== 1'b1);
    access_rsp_q.push_back(decode_access('{req_type: kind, bus_address: addr,
                                           write_data: data}));
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (access_rsp_q.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // response side: random stalls, in-order compare
  initial begin : rsp_check
    int       stall;
    snd_rsp_t want;
    out_ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      stall = rx_idle_on ? $urandom_range(0, MAX_IDLE) : 0;
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (out_valid !== 1'b1);
      if (access_rsp_q.size() == 0) begin
        report_mismatch("response without request", 8'h00, out_rsp.read_data);
      end else begin
        want = access_rsp_q.pop_front();
        if (out_rsp.read_data !== want.read_data)
          report_mismatch("read_data", want.read_data, out_rsp.read_data);
        if (out_rsp.mapped !== want.mapped)
          report_mismatch("mapped", {7'd0, want.mapped}, {7'd0, out_rsp.mapped});
      end
    end
  end

  task automatic test_reset_values();
    send_request(REQ_READ, 16'hFF10, 8'h00);
    send_request(REQ_READ, 16'hFF11, 8'h00);
    send_request(REQ_READ, 16'hFF13, 8'h00);
    send_request(REQ_READ, 16'hFF1A, 8'h00);
    send_request(REQ_READ, 16'hFF26, 8'h00);
    send_request(REQ_READ, WAVE_FIRST, 8'h00);
    send_request(REQ_READ, WAVE_LAST, 8'h00);
  endtask

  task automatic test_register_masks();
    send_request(REQ_WRITE, 16'hFF1E, 8'hFF);
    send_request(REQ_READ, 16'hFF1E, 8'h00);
    send_request(REQ_WRITE, 16'hFF1E, 8'h00);
    send_request(REQ_READ, 16'hFF1E, 8'hFF);
    send_request(REQ_WRITE, 16'hFF23, 8'hFF);
    send_request(REQ_READ, 16'hFF23, 8'h00);
    send_request(REQ_WRITE, 16'hFF1C, 8'h00);
    send_request(REQ_READ, 16'hFF1C, 8'h00);
  endtask

  task automatic test_wave_store();
    send_request(REQ_WRITE, WAVE_FIRST, 8'hFF);
    send_request(REQ_WRITE, WAVE_LAST, 8'hA5);
    send_request(REQ_READ, WAVE_FIRST, 8'h00);
    send_request(REQ_READ, WAVE_LAST, 8'h00);
  endtask

  task automatic test_unmapped();
    send_request(REQ_READ, 16'h0000, 8'h00);
    send_request(REQ_READ, 16'hFFFF, 8'hFF);
    send_request(REQ_WRITE, 16'hFF15, 8'hAA);
    send_request(REQ_READ, 16'hFF15, 8'h00);
    send_request(REQ_READ, 16'hFF1F, 8'h00);
    send_request(REQ_READ, 16'hFF27, 8'h00);
    send_request(REQ_READ, 16'hFF2F, 8'h00);
    send_request(REQ_WRITE, 16'hFF40, 8'h55);
  endtask

  task automatic test_drain_pause();
    send_request(REQ_WRITE, 16'hFF24, 8'h5A);
    send_request(REQ_READ, 16'hFF24, 8'h00);
    wait_drained();
    send_request(REQ_READ, 16'hFF24, 8'h00);
    send_request(REQ_READ, 16'hFF0F, 8'h00);
  endtask

  task automatic test_random_traffic();
    logic [15:0] addr;
    logic [7:0]  data;
    logic        kind;
    for (int seg = 0; seg < 13; seg++) begin
      tx_idle_on = ($urandom_range(0, 3) != 0);
      rx_idle_on = ($urandom_range(0, 3) != 0);
      for (int n = 0; n < 100; n++) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4, 5: addr = SND_FIRST + 16'($urandom_range(0, NUM_SLOTS - 1));
          6, 7:             addr = WAVE_FIRST + 16'($urandom_range(0, NUM_WAVE - 1));
          8:                addr = 16'hFF00 + 16'($urandom_range(0, 8'h4F));
          default:          addr = 16'($urandom);
        endcase
        kind = 1'($urandom);
        data = ($urandom_range(0, 7) == 0) ? {8{kind}} : 8'($urandom);
        send_request(kind, addr, data);
      end
      if (seg == 6)
        wait_drained();
    end
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
  endtask

  initial begin : run_limit
    #2ms;
    $display("[sound_unit_register_file] ERROR");
    $finish;
  end

  initial begin : main_seq
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_req   <= '0;
    foreach (slot_shadow[i]) slot_shadow[i] = SLOT_INIT[i];
    foreach (wave_shadow[i]) wave_shadow[i] = 8'h00;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_values();
    test_register_masks();
    test_wave_store();
    test_unmapped();
    test_drain_pause();
    test_random_traffic();
    wait_drained();
    if (mismatch_count == 0) begin
      $display("[sound_unit_register_file] OK");
    end else begin
      $display("[sound_unit_register_file] ERROR");
    end
    $finish;
  end

endmodule
